// ----- design/vna_pkg.sv -----
package vna_pkg;

    // Operation codes of an input request
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_TRIANGLE = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // Register indexes of the configuration port
    localparam logic REG_FIRST_VERTEX = 1'b0;
    localparam logic REG_PART_OPEN    = 1'b1;

    // Fixed field widths
    localparam int POS_W   = 24;
    localparam int NORM_W  = 16;
    localparam int INDEX_W = 32;
    localparam int ACC_W   = 56;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int FACE_W  = PROD_W + 1;
    localparam int MAG_W   = 24;
    localparam int SUM_W   = 2 * MAG_W + 2;
    localparam int ROOT_W  = MAG_W + 1;
    localparam int QUO_W   = 16;
    localparam int NUM_W   = MAG_W + 15;

    // Iteration counts of the root and divide units
    localparam logic [4:0] ROOT_ITERS = 5'd25;
    localparam logic [4:0] DIV_ITERS  = 5'd16;
    localparam logic [QUO_W-1:0] UNIT_NORMAL = 16'd16384;

    // Datapath step selected by the controller
    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_POS_RD,
        DP_CROSS,
        DP_ACC_RD,
        DP_ACC_WR,
        DP_FIN_RD,
        DP_FIN_LAT,
        DP_SHIFT,
        DP_SQUARE,
        DP_ROOT_INIT,
        DP_ROOT,
        DP_DIV_INIT,
        DP_DIV,
        DP_DIV_END,
        DP_EMIT,
        DP_CLEAR
    } dp_step_t;

    typedef struct packed {
        logic     capture;
        dp_step_t step;
        logic [1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       tri_ok;
        logic       full;
        logic       part_open;
        logic       empty;
        logic       acc_zero;
        logic       big;
        logic       out_free;
        logic       last_slot;
    } dp_status_t;

endpackage

// ----- design/vna_ctrl.sv -----
module vna_ctrl
    import vna_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_POS_RD,
        S_CROSS,
        S_ACC_RD,
        S_ACC_WR,
        S_FIN_RD,
        S_FIN_LAT,
        S_SHIFT,
        S_SQUARE,
        S_ROOT_INIT,
        S_ROOT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_EMIT,
        S_CLEAR
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [4:0] iter_reg, iter_next;
    logic       stall_reg;

    // Pick the next state and counters
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                idx_next = 2'd0;
                case (status.op)
                    OP_LOAD:     state_next = S_LOAD;
                    OP_TRIANGLE: state_next = status.tri_ok ? S_POS_RD : S_IDLE;
                    OP_FINISH:
                    begin
                        if (!status.part_open)
                            state_next = S_IDLE;
                        else if (status.empty)
                            state_next = S_CLEAR;
                        else
                            state_next = S_FIN_RD;
                    end
                    default:     state_next = S_IDLE;
                endcase
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_POS_RD:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = S_CROSS;
            end
            S_CROSS:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = S_ACC_RD;
            end
            S_ACC_RD:
            begin
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd2) ? S_IDLE : S_ACC_RD;
            end
            S_FIN_RD:
            begin
                state_next = S_FIN_LAT;
            end
            S_FIN_LAT:
            begin
                idx_next = 2'd0;
                state_next = status.acc_zero ? S_EMIT : S_SHIFT;
            end
            S_SHIFT:
            begin
                if (!status.big)
                    state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = S_ROOT_INIT;
            end
            S_ROOT_INIT:
            begin
                iter_next  = 5'd0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                iter_next = iter_reg + 5'd1;
                if (iter_reg == ROOT_ITERS - 5'd1)
                begin
                    idx_next   = 2'd0;
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                iter_next  = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                iter_next = iter_reg + 5'd1;
                if (iter_reg == DIV_ITERS - 5'd1)
                    state_next = S_DIV_END;
            end
            S_DIV_END:
            begin
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd2) ? S_EMIT : S_DIV_INIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = status.last_slot ? S_CLEAR : S_FIN_RD;
            end
            S_CLEAR:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and the registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
            iter_reg  <= 5'd0;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            iter_reg  <= iter_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = stall_reg;

    // Map state to a datapath step
    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.idx     = idx_reg;
        case (state_reg)
            S_LOAD:      cmd.step = status.full ? DP_IDLE : DP_LOAD;
            S_POS_RD:    cmd.step = DP_POS_RD;
            S_CROSS:     cmd.step = DP_CROSS;
            S_ACC_RD:    cmd.step = DP_ACC_RD;
            S_ACC_WR:    cmd.step = DP_ACC_WR;
            S_FIN_RD:    cmd.step = DP_FIN_RD;
            S_FIN_LAT:   cmd.step = DP_FIN_LAT;
            S_SHIFT:     cmd.step = DP_SHIFT;
            S_SQUARE:    cmd.step = DP_SQUARE;
            S_ROOT_INIT: cmd.step = DP_ROOT_INIT;
            S_ROOT:      cmd.step = DP_ROOT;
            S_DIV_INIT:  cmd.step = DP_DIV_INIT;
            S_DIV:       cmd.step = DP_DIV;
            S_DIV_END:   cmd.step = DP_DIV_END;
            S_EMIT:      cmd.step = status.out_free ? DP_EMIT : DP_IDLE;
            S_CLEAR:     cmd.step = DP_CLEAR;
            default:     cmd.step = DP_IDLE;
        endcase
    end

endmodule

// ----- design/vna_datapath.sv -----
module vna_datapath
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic [INDEX_W-1:0]        first_vertex,
    input  logic                      part_open,
    input  logic [1:0]                operation,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic signed [NORM_W-1:0]  prior_nx,
    input  logic signed [NORM_W-1:0]  prior_ny,
    input  logic signed [NORM_W-1:0]  prior_nz,
    input  logic [INDEX_W-1:0]        corner_a,
    input  logic [INDEX_W-1:0]        corner_b,
    input  logic [INDEX_W-1:0]        corner_c,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [INDEX_W-1:0]        vertex_index,
    output logic signed [NORM_W-1:0]  normal_x,
    output logic signed [NORM_W-1:0]  normal_y,
    output logic signed [NORM_W-1:0]  normal_z,
    output logic                      last
);

    localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VERTICES);

    // Captured request
    logic [1:0]               op_reg;
    logic [3*POS_W-1:0]       pos_in_reg;
    logic [3*NORM_W-1:0]      prior_in_reg;
    logic [INDEX_W-1:0]       corner_reg [3];

    // Store bookkeeping
    logic [CW-1:0]            count_reg;
    logic [SW-1:0]            slot_reg;

    // Memories
    logic [3*POS_W-1:0]       pos_mem   [MAX_VERTICES];
    logic [3*NORM_W-1:0]      prior_mem [MAX_VERTICES];
    logic [3*ACC_W-1:0]       acc_mem   [MAX_VERTICES];
    logic [3*POS_W-1:0]       pos_q;
    logic [3*NORM_W-1:0]      prior_q;
    logic [3*ACC_W-1:0]       acc_q;

    // Triangle arithmetic
    logic [INDEX_W-1:0]       off      [3];
    logic                     in_rng   [3];
    logic [SW-1:0]            tslot    [3];
    logic [SW-1:0]            sel_slot;
    logic signed [POS_W-1:0]  pa_reg   [3];
    logic signed [DIFF_W-1:0] u_reg    [3];
    logic signed [DIFF_W-1:0] v_reg    [3];
    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [DIFF_W-1:0] ma, mb, mc, md;
    logic signed [FACE_W-1:0] f_reg    [3];
    logic [3*ACC_W-1:0]       acc_sum;

    // Normalisation arithmetic
    logic [ACC_W-1:0]         m_reg    [3];
    logic                     neg_reg  [3];
    logic                     zero_reg;
    logic [2*MAG_W-1:0]       sq_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         rs_reg;
    logic [SUM_W-1:0]         res_reg;
    logic [SUM_W-1:0]         bit_reg;
    logic [SUM_W:0]           root_try;
    logic [ROOT_W-1:0]        root;
    logic [NUM_W-1:0]         num;
    logic [ROOT_W:0]          rem_reg;
    logic [QUO_W-1:0]         numlo_reg;
    logic [QUO_W-1:0]         q_reg;
    logic [ROOT_W:0]          div_try;
    logic [QUO_W-1:0]         q_sat;
    logic [MAG_W-1:0]         m_sel;
    logic signed [NORM_W-1:0] n_reg    [3];

    // Output register
    logic                     out_valid_reg;
    logic [INDEX_W-1:0]       index_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic                     last_reg;
    logic                     out_free;
    logic                     last_slot;

    // Capture the request at acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= operation;
            pos_in_reg    <= {pos_z, pos_y, pos_x};
            prior_in_reg  <= {prior_nz, prior_ny, prior_nx};
            corner_reg[0] <= corner_a;
            corner_reg[1] <= corner_b;
            corner_reg[2] <= corner_c;
        end
    end

    // Map corners onto slots and check the range
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            off[k]    = corner_reg[k] - first_vertex;
            in_rng[k] = (corner_reg[k] >= first_vertex) &&
                        (off[k] < INDEX_W'(count_reg));
            tslot[k]  = off[k][SW-1:0];
        end
        case (cmd.idx)
            2'd0:    sel_slot = tslot[0];
            2'd1:    sel_slot = tslot[1];
            default: sel_slot = tslot[2];
        endcase
    end

    // Count loaded slots and walk them on finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            case (cmd.step)
                DP_LOAD:  count_reg <= count_reg + CW'(1);
                DP_EMIT:  slot_reg  <= slot_reg + SW'(1);
                DP_CLEAR:
                begin
                    count_reg <= '0;
                    slot_reg  <= '0;
                end
                default:  ;
            endcase
        end
    end

    // Position and prior normal stores
    always_ff @(posedge clk)
    begin
        if (cmd.step == DP_LOAD)
        begin
            pos_mem[count_reg[SW-1:0]]   <= pos_in_reg;
            prior_mem[count_reg[SW-1:0]] <= prior_in_reg;
        end
        pos_q   <= pos_mem[sel_slot];
        prior_q <= prior_mem[slot_reg];
    end

    // Saturating add of the face normal onto the read accumulator
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [ACC_W:0] s;
            s = {acc_q[k*ACC_W+ACC_W-1], acc_q[k*ACC_W +: ACC_W]} +
                (ACC_W+1)'(f_reg[k]);
            if (s[ACC_W] != s[ACC_W-1])
                acc_sum[k*ACC_W +: ACC_W] = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                     : {1'b0, {(ACC_W-1){1'b1}}};
            else
                acc_sum[k*ACC_W +: ACC_W] = s[ACC_W-1:0];
        end
    end

    // Accumulator store: zero on load, read and update per corner, read on finish
    always_ff @(posedge clk)
    begin
        if (cmd.step == DP_LOAD)
            acc_mem[count_reg[SW-1:0]] <= '0;
        else if (cmd.step == DP_ACC_WR)
            acc_mem[sel_slot] <= acc_sum;
        acc_q <= acc_mem[(cmd.step == DP_FIN_RD) ? slot_reg : sel_slot];
    end

    // Corner differences
    always_ff @(posedge clk)
    begin
        if (cmd.step == DP_POS_RD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (cmd.idx == 2'd1)
                    pa_reg[k] <= pos_q[k*POS_W +: POS_W];
                if (cmd.idx == 2'd2)
                    u_reg[k] <= DIFF_W'(signed'(pos_q[k*POS_W +: POS_W])) -
                                DIFF_W'(pa_reg[k]);
                if (cmd.idx == 2'd3)
                    v_reg[k] <= DIFF_W'(signed'(pos_q[k*POS_W +: POS_W])) -
                                DIFF_W'(pa_reg[k]);
            end
        end
    end

    // Cross product operands, one component per step
    always_comb
    begin
        case (cmd.idx)
            2'd0:
            begin
                ma = u_reg[1]; mb = v_reg[2]; mc = u_reg[2]; md = v_reg[1];
            end
            2'd1:
            begin
                ma = u_reg[2]; mb = v_reg[0]; mc = u_reg[0]; md = v_reg[2];
            end
            default:
            begin
                ma = u_reg[0]; mb = v_reg[1]; mc = u_reg[1]; md = v_reg[0];
            end
        endcase
    end

    // Multiply, then subtract the registered products a step later
    always_ff @(posedge clk)
    begin
        if (cmd.step == DP_CROSS)
        begin
            p0_reg <= ma * mb;
            p1_reg <= mc * md;
            case (cmd.idx)
                2'd1:    f_reg[0] <= FACE_W'(p0_reg) - FACE_W'(p1_reg);
                2'd2:    f_reg[1] <= FACE_W'(p0_reg) - FACE_W'(p1_reg);
                2'd3:    f_reg[2] <= FACE_W'(p0_reg) - FACE_W'(p1_reg);
                default: ;
            endcase
        end
    end

    // Square root step, one result bit per cycle
    assign root_try = {1'b0, res_reg} + {1'b0, bit_reg};
    assign root     = (res_reg[ROOT_W-1:0] == '0) ? ROOT_W'(1) : res_reg[ROOT_W-1:0];

    // Divide operands
    always_comb
    begin
        case (cmd.idx)
            2'd0:    m_sel = m_reg[0][MAG_W-1:0];
            2'd1:    m_sel = m_reg[1][MAG_W-1:0];
            default: m_sel = m_reg[2][MAG_W-1:0];
        endcase
        num     = {m_sel, 14'd0} + NUM_W'(root >> 1);
        div_try = {rem_reg[ROOT_W-1:0], numlo_reg[QUO_W-1]};
        q_sat   = (q_reg > UNIT_NORMAL) ? UNIT_NORMAL : q_reg;
    end

    // Normalise: magnitudes, shift, squares, root, divide
    always_ff @(posedge clk)
    begin
        case (cmd.step)
            DP_FIN_LAT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= acc_q[k*ACC_W+ACC_W-1];
                    m_reg[k]   <= acc_q[k*ACC_W+ACC_W-1] ? -acc_q[k*ACC_W +: ACC_W]
                                                         : acc_q[k*ACC_W +: ACC_W];
                end
                zero_reg <= (acc_q == '0);
            end
            DP_SHIFT:
            begin
                if (status.big)
                begin
                    for (int k = 0; k < 3; k++)
                        m_reg[k] <= m_reg[k] >> 1;
                end
            end
            DP_SQUARE:
            begin
                case (cmd.idx)
                    2'd0:    sq_reg <= m_reg[0][MAG_W-1:0] * m_reg[0][MAG_W-1:0];
                    2'd1:    sq_reg <= m_reg[1][MAG_W-1:0] * m_reg[1][MAG_W-1:0];
                    default: sq_reg <= m_reg[2][MAG_W-1:0] * m_reg[2][MAG_W-1:0];
                endcase
                if (cmd.idx == 2'd0)
                    sum_reg <= '0;
                else
                    sum_reg <= sum_reg + SUM_W'(sq_reg);
            end
            DP_ROOT_INIT:
            begin
                rs_reg  <= sum_reg;
                res_reg <= '0;
                bit_reg <= SUM_W'(1) << (SUM_W - 2);
            end
            DP_ROOT:
            begin
                if ({1'b0, rs_reg} >= root_try)
                begin
                    rs_reg  <= rs_reg - root_try[SUM_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            DP_DIV_INIT:
            begin
                rem_reg   <= (ROOT_W+1)'(num[NUM_W-1:QUO_W]);
                numlo_reg <= num[QUO_W-1:0];
                q_reg     <= '0;
            end
            DP_DIV:
            begin
                if (div_try >= {1'b0, root})
                begin
                    rem_reg <= div_try - {1'b0, root};
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_try;
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
                end
                numlo_reg <= numlo_reg << 1;
            end
            DP_DIV_END:
            begin
                case (cmd.idx)
                    2'd0:    n_reg[0] <= neg_reg[0] ? -signed'(q_sat) : signed'(q_sat);
                    2'd1:    n_reg[1] <= neg_reg[1] ? -signed'(q_sat) : signed'(q_sat);
                    default: n_reg[2] <= neg_reg[2] ? -signed'(q_sat) : signed'(q_sat);
                endcase
            end
            default: ;
        endcase
    end

    // Output register: load on emit, drop when taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_slot = (CW'(slot_reg) + CW'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.step == DP_EMIT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == DP_EMIT)
        begin
            index_reg <= first_vertex + INDEX_W'(slot_reg);
            last_reg  <= last_slot;
            if (zero_reg)
            begin
                nx_reg <= prior_q[0*NORM_W +: NORM_W];
                ny_reg <= prior_q[1*NORM_W +: NORM_W];
                nz_reg <= prior_q[2*NORM_W +: NORM_W];
            end
            else
            begin
                nx_reg <= n_reg[0];
                ny_reg <= n_reg[1];
                nz_reg <= n_reg[2];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = index_reg;
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign last         = last_reg;

    // Status back to the controller
    always_comb
    begin
        status.op        = op_reg;
        status.tri_ok    = in_rng[0] && in_rng[1] && in_rng[2];
        status.full      = (count_reg == COUNT_MAX);
        status.part_open = part_open;
        status.empty     = (count_reg == '0);
        status.acc_zero  = (acc_q == '0);
        status.big       = (m_reg[0][ACC_W-1:MAG_W] != '0) ||
                           (m_reg[1][ACC_W-1:MAG_W] != '0) ||
                           (m_reg[2][ACC_W-1:MAG_W] != '0);
        status.out_free  = out_free;
        status.last_slot = last_slot;
    end

endmodule

// ----- design/vertex_normal_accumulator.sv -----
// Smooth area-weighted vertex normals for one mesh part.
// Configure first_vertex (address 0) and part_open (address 4) over the APB
// port while the block is idle; pready is always high and reads return values.
// Input requests use in_valid / in_stall: a load stores a vertex in the next
// free slot unless the store is full, a triangle whose corners all lie in the
// loaded range adds its face normal cross(b-a, c-a) to the three corner
// accumulators with saturation, reading the corners through the single read
// port of the position store and then doing a read-modify-write per corner; a
// finish while part_open is set emits one result per loaded vertex and then
// empties the store. Each emitted normal goes through range shifting, three
// squares, a 25-step square root and three 16-step divides through one shared
// divider. A zero sum gives back the stored prior normal.
// One request is worked at a time; in_stall stays high until it is done.
// Results leave through an output register on out_valid / out_stall; while
// out_stall holds a result, the finish pauses before the next one, and a new
// request may be taken while the last result still waits.
// Reset empties the store and clears both registers; memory contents need no
// clearing since a slot is rewritten before it is read.
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic signed [NORM_W-1:0]  prior_nx,
    input  logic signed [NORM_W-1:0]  prior_ny,
    input  logic signed [NORM_W-1:0]  prior_nz,
    input  logic [INDEX_W-1:0]        corner_a,
    input  logic [INDEX_W-1:0]        corner_b,
    input  logic [INDEX_W-1:0]        corner_c,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [INDEX_W-1:0]        vertex_index,
    output logic signed [NORM_W-1:0]  normal_x,
    output logic signed [NORM_W-1:0]  normal_y,
    output logic signed [NORM_W-1:0]  normal_z,
    output logic                      last
);

    logic [INDEX_W-1:0] first_vertex_reg;
    logic               part_open_reg;
    logic               cfg_write;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_vertex_reg <= '0;
            part_open_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_FIRST_VERTEX: first_vertex_reg <= pwdata;
                REG_PART_OPEN:    part_open_reg    <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FIRST_VERTEX: prdata = first_vertex_reg;
            REG_PART_OPEN:    prdata = {31'd0, part_open_reg};
            default:          prdata = '0;
        endcase
    end

    vna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vna_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .first_vertex (first_vertex_reg),
        .part_open    (part_open_reg),
        .operation    (operation),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .prior_nx     (prior_nx),
        .prior_ny     (prior_ny),
        .prior_nz     (prior_nz),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vertex_index (vertex_index),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .last         (last)
    );

endmodule
